// ===== hw/rtl/tksi_pkg.sv =====
// shared types for the top-k sorted insertion list
// entry layout, op and result kind codes, controller to datapath command/status
// no dependencies
package tksi_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DUMP   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_DUMP   = 2'd1,
        KIND_CLEAR  = 2'd2
    } t_kind;

    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  proto;
        logic [63:0] value;
    } t_entry;

    typedef struct packed {
        logic latch;
        logic idx_clr;
        logic idx_inc;
        logic rd_idx;
        logic pos_from_idx;
        logic j_load;
        logic rd_shift;
        logic wr_shift;
        logic wr_key;
        logic cnt_clr;
        logic emit_plain;
        logic emit_entry;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_end;
        logic hit;
        logic refuse;
        logic shift_done;
        logic empty;
        logic dump_last;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== hw/rtl/top_k_sorted_insert.sv =====
// top-k sorted insertion list: bounded list of flow keys, descending by value
// input channel takes ops (insert, dump, clear); output channel returns results
// input channel: i_in_valid/o_in_ready with op and key fields, one transfer per op
// output channel: o_out_valid/i_out_ready, one transfer per result, o_last on the final one
// insert: the scan reads entries from the head until the key's place is found; the shift then
// moves each entry below that place down by one, a read and then a write, and the key is written
// there; once the list is full the last entry drops out, or the key is refused if it ranks below
// every entry; the entry memory takes one access at a time, a read or a write
// dump of n entries: one result per entry, each read from the entry memory and then registered
// clear and empty dump: a single result with no entry, loaded into the output register from the emit state
// one op is worked at a time; o_in_ready is high only while the controller is idle, from the
// same edge that loads the final result, and it may be high while that result still waits
// reset empties the list and drops any pending result; no memory clearing pass
// a stalled receiver holds the output register and the controller waits on it
// depends on tksi_pkg, tksi_ctrl, tksi_dpath
module top_k_sorted_insert #(
    parameter int CAPACITY = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [1:0]                       i_op,
    input  logic [31:0]                      i_src_addr,
    input  logic [31:0]                      i_dst_addr,
    input  logic [15:0]                      i_src_port_in,
    input  logic [15:0]                      i_dst_port_in,
    input  logic [7:0]                       i_proto_in,
    input  logic [63:0]                      i_sort_value,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [1:0]                       o_kind,
    output logic [$clog2(CAPACITY+1)-1:0]    o_position,
    output logic [31:0]                      o_out_src_addr,
    output logic [31:0]                      o_out_dst_addr,
    output logic [15:0]                      o_out_src_port,
    output logic [15:0]                      o_out_dst_port,
    output logic [7:0]                       o_out_proto,
    output logic [63:0]                      o_out_value,
    output logic                             o_tied,
    output logic                             o_entry_valid,
    output logic                             o_last
);
    import tksi_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;
    t_entry  key;
    t_entry  out_entry;

    assign key.src   = i_src_addr;
    assign key.dst   = i_dst_addr;
    assign key.sport = i_src_port_in;
    assign key.dport = i_dst_port_in;
    assign key.proto = i_proto_in;
    assign key.value = i_sort_value;

    tksi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_op       (i_op),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tksi_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_op          (i_op),
        .i_key         (key),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_kind        (o_kind),
        .o_position    (o_position),
        .o_entry       (out_entry),
        .o_tied        (o_tied),
        .o_entry_valid (o_entry_valid),
        .o_last        (o_last)
    );

    assign o_out_src_addr = out_entry.src;
    assign o_out_dst_addr = out_entry.dst;
    assign o_out_src_port = out_entry.sport;
    assign o_out_dst_port = out_entry.dport;
    assign o_out_proto    = out_entry.proto;
    assign o_out_value    = out_entry.value;

endmodule

// ===== hw/rtl/tksi_dpath.sv =====
// datapath: entry memory, scan/shift counters, input latch and output register
// depends on tksi_pkg
module tksi_dpath #(
    parameter int CAPACITY = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  tksi_pkg::t_dp_cmd                i_cmd,
    output tksi_pkg::t_dp_sts                o_sts,
    input  logic [1:0]                       i_op,
    input  tksi_pkg::t_entry                 i_key,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [1:0]                       o_kind,
    output logic [$clog2(CAPACITY+1)-1:0]    o_position,
    output tksi_pkg::t_entry                 o_entry,
    output logic                             o_tied,
    output logic                             o_entry_valid,
    output logic                             o_last
);
    import tksi_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int PW = $clog2(CAPACITY + 1);
    localparam logic [PW-1:0] CAP_P    = PW'(CAPACITY);
    localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);

    t_entry          mem [CAPACITY];
    t_entry          r_key;
    t_entry          r_rd;
    t_op             r_op;
    logic [PW-1:0]   r_idx;
    logic [PW-1:0]   r_pos;
    logic [PW-1:0]   r_count;
    logic [IW-1:0]   r_j;
    logic [63:0]     r_prev;

    logic            r_out_valid;
    t_kind           r_kind;
    logic [PW-1:0]   r_position;
    t_entry          r_out_entry;
    logic            r_tied;
    logic            r_entry_valid;
    logic            r_last;

    logic            rd_en;
    logic [IW-1:0]   rd_addr;
    logic            wr_en;
    logic [IW-1:0]   wr_addr;
    t_entry          wr_data;
    logic [IW-1:0]   top_idx;
    logic            dump_last;

    assign rd_en   = i_cmd.rd_idx | i_cmd.rd_shift;
    assign rd_addr = i_cmd.rd_shift ? IW'(r_j - 1'b1) : r_idx[IW-1:0];
    assign wr_en   = i_cmd.wr_key | i_cmd.wr_shift;
    assign wr_addr = i_cmd.wr_key ? r_pos[IW-1:0] : r_j;
    assign wr_data = i_cmd.wr_key ? r_key : r_rd;
    assign top_idx = (r_count == CAP_P) ? LAST_IDX : r_count[IW-1:0];
    assign dump_last = ((r_idx + PW'(1)) == r_count);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    always_comb begin
        o_sts.scan_end   = (r_idx == r_count);
        o_sts.hit        = (r_rd.value < r_key.value) ||
                           ((r_rd.value == r_key.value) &&
                            (r_rd.src[31:24] > r_key.src[31:24]));
        o_sts.refuse     = (r_pos == CAP_P);
        o_sts.shift_done = (PW'(r_j) == r_pos);
        o_sts.empty      = (r_count == '0);
        o_sts.dump_last  = dump_last;
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_key <= i_key;
            r_op  <= t_op'(i_op);
        end
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + PW'(1);
        end
        if (i_cmd.pos_from_idx) begin
            r_pos <= r_idx;
        end
        if (i_cmd.j_load) begin
            r_j <= top_idx;
        end else if (i_cmd.wr_shift) begin
            r_j <= r_j - 1'b1;
        end
        if (i_cmd.emit_entry) begin
            r_prev <= r_rd.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.cnt_clr) begin
            r_count <= '0;
        end else if (i_cmd.wr_key && r_count != CAP_P) begin
            r_count <= r_count + PW'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_plain || i_cmd.emit_entry) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_plain) begin
            r_kind        <= t_kind'(2'(r_op));
            r_position    <= (r_op == OP_INSERT) ? r_pos : '0;
            r_out_entry   <= '0;
            r_tied        <= 1'b0;
            r_entry_valid <= 1'b0;
            r_last        <= 1'b1;
        end else if (i_cmd.emit_entry) begin
            r_kind        <= KIND_DUMP;
            r_position    <= r_idx;
            r_out_entry   <= r_rd;
            r_tied        <= (r_idx != '0) && (r_rd.value == r_prev);
            r_entry_valid <= 1'b1;
            r_last        <= dump_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_position    = r_position;
    assign o_entry       = r_out_entry;
    assign o_tied        = r_tied;
    assign o_entry_valid = r_entry_valid;
    assign o_last        = r_last;

endmodule

// ===== hw/rtl/tksi_ctrl.sv =====
// controller: sequences scan, shift, dump and result transfers
// depends on tksi_pkg
module tksi_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_op,
    input  tksi_pkg::t_dp_sts  i_sts,
    output tksi_pkg::t_dp_cmd  o_cmd
);
    import tksi_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_DECIDE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_EMIT,
        S_DUMP_RD,
        S_DUMP_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.latch   = 1'b1;
                    o_cmd.idx_clr = 1'b1;
                    case (t_op'(i_op))
                        OP_INSERT: n_state = S_SCAN_RD;
                        OP_DUMP:   n_state = i_sts.empty ? S_EMIT : S_DUMP_RD;
                        OP_CLEAR: begin
                            o_cmd.cnt_clr = 1'b1;
                            n_state       = S_EMIT;
                        end
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN_RD: begin
                if (i_sts.scan_end) begin
                    o_cmd.pos_from_idx = 1'b1;
                    n_state            = S_DECIDE;
                end else begin
                    o_cmd.rd_idx = 1'b1;
                    n_state      = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                if (i_sts.hit) begin
                    o_cmd.pos_from_idx = 1'b1;
                    n_state            = S_DECIDE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_SCAN_RD;
                end
            end
            S_DECIDE: begin
                if (i_sts.refuse) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.j_load = 1'b1;
                    n_state      = S_SHIFT_RD;
                end
            end
            S_SHIFT_RD: begin
                if (i_sts.shift_done) begin
                    o_cmd.wr_key = 1'b1;
                    n_state      = S_EMIT;
                end else begin
                    o_cmd.rd_shift = 1'b1;
                    n_state        = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                o_cmd.wr_shift = 1'b1;
                n_state        = S_SHIFT_RD;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_plain = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_DUMP_RD: begin
                o_cmd.rd_idx = 1'b1;
                n_state      = S_DUMP_OUT;
            end
            S_DUMP_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_entry = 1'b1;
                    o_cmd.idx_inc    = 1'b1;
                    n_state          = i_sts.dump_last ? S_IDLE : S_DUMP_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== tb/tksi_list_checker.sv =====
// checker for the top-k sorted insertion list: watches both channels, keeps its own
// ranked copy of the list, predicts every result and compares it field by field
// depends on tksi_pkg
module tksi_list_checker #(
    parameter int CAPACITY = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [1:0]                    i_op,
    input  logic [31:0]                   i_src_addr,
    input  logic [31:0]                   i_dst_addr,
    input  logic [15:0]                   i_src_port_in,
    input  logic [15:0]                   i_dst_port_in,
    input  logic [7:0]                    i_proto_in,
    input  logic [63:0]                   i_sort_value,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [1:0]                    i_kind,
    input  logic [$clog2(CAPACITY+1)-1:0] i_position,
    input  logic [31:0]                   i_out_src_addr,
    input  logic [31:0]                   i_out_dst_addr,
    input  logic [15:0]                   i_out_src_port,
    input  logic [15:0]                   i_out_dst_port,
    input  logic [7:0]                    i_out_proto,
    input  logic [63:0]                   i_out_value,
    input  logic                          i_tied,
    input  logic                          i_entry_valid,
    input  logic                          i_last,
    output int                            o_errors,
    output int                            o_pending,
    output int                            o_results,
    output int                            o_refused
);
    timeunit 1ns;
    timeprecision 1ps;
    import tksi_pkg::*;

    localparam int PW        = $clog2(CAPACITY + 1);
    localparam int PRINT_CAP = 60;

    typedef struct packed {
        t_kind         kind;
        logic [PW-1:0] position;
        t_entry        entry;
        logic          tied;
        logic          entry_valid;
        logic          last;
    } t_result;

    t_entry  ranked_keys [CAPACITY];
    int      ranked_count;
    t_result expected_results [$];
    t_entry  seen_key;
    int      errors;
    int      checked;
    int      refused;

    initial begin
        ranked_count = 0;
        errors       = 0;
        checked      = 0;
        refused      = 0;
        o_errors     = 0;
        o_pending    = 0;
        o_results    = 0;
        o_refused    = 0;
    end

    task automatic report(input string msg);
        errors++;
        if (errors <= PRINT_CAP) begin
            $display("mismatch at %0t ns: %s", $time, msg);
        end
    endtask

    task automatic push_result(input t_kind kind, input int position, input t_entry entry,
                               input logic tied, input logic entry_valid, input logic last);
        t_result r;
        r.kind        = kind;
        r.position    = PW'(position);
        r.entry       = entry;
        r.tied        = tied;
        r.entry_valid = entry_valid;
        r.last        = last;
        expected_results.push_back(r);
    endtask

    task automatic predict_results(input t_op op, input t_entry key);
        int   pos;
        int   top_idx;
        logic found;
        found = 1'b0;
        pos   = ranked_count;
        case (op)
            OP_INSERT: begin
                for (int i = 0; i < ranked_count; i++) begin
                    if (!found && (ranked_keys[i].value < key.value ||
                                   (ranked_keys[i].value == key.value &&
                                    ranked_keys[i].src[31:24] > key.src[31:24]))) begin
                        pos   = i;
                        found = 1'b1;
                    end
                end
                if (pos >= CAPACITY) begin
                    refused++;
                    push_result(KIND_INSERT, CAPACITY, '0, 1'b0, 1'b0, 1'b1);
                end else begin
                    top_idx = (ranked_count < CAPACITY) ? ranked_count : CAPACITY - 1;
                    for (int i = top_idx; i > pos; i--) begin
                        ranked_keys[i] = ranked_keys[i-1];
                    end
                    ranked_keys[pos] = key;
                    if (ranked_count < CAPACITY) begin
                        ranked_count++;
                    end
                    push_result(KIND_INSERT, pos, '0, 1'b0, 1'b0, 1'b1);
                end
            end
            OP_DUMP: begin
                if (ranked_count == 0) begin
                    push_result(KIND_DUMP, 0, '0, 1'b0, 1'b0, 1'b1);
                end else begin
                    for (int i = 0; i < ranked_count; i++) begin
                        push_result(KIND_DUMP, i, ranked_keys[i],
                                    i > 0 && ranked_keys[i].value == ranked_keys[i-1].value,
                                    1'b1, i == ranked_count - 1);
                    end
                end
            end
            OP_CLEAR: begin
                ranked_count = 0;
                push_result(KIND_CLEAR, 0, '0, 1'b0, 1'b0, 1'b1);
            end
            default: begin
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            report($sformatf("result %0d %s got 0x%0h expected 0x%0h",
                             checked, name, got, want));
        end
    endtask

    task automatic check_result();
        t_result want;
        if (expected_results.size() == 0) begin
            report($sformatf("unexpected transfer, kind %0d position %0d",
                             i_kind, i_position));
            return;
        end
        want = expected_results.pop_front();
        check_field("kind", 64'(i_kind), 64'(want.kind));
        check_field("position", 64'(i_position), 64'(want.position));
        check_field("src_addr", 64'(i_out_src_addr), 64'(want.entry.src));
        check_field("dst_addr", 64'(i_out_dst_addr), 64'(want.entry.dst));
        check_field("src_port", 64'(i_out_src_port), 64'(want.entry.sport));
        check_field("dst_port", 64'(i_out_dst_port), 64'(want.entry.dport));
        check_field("proto", 64'(i_out_proto), 64'(want.entry.proto));
        check_field("value", i_out_value, want.entry.value);
        check_field("tied", 64'(i_tied), 64'(want.tied));
        check_field("entry_valid", 64'(i_entry_valid), 64'(want.entry_valid));
        check_field("last", 64'(i_last), 64'(want.last));
        checked++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ranked_count = 0;
            expected_results.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                seen_key = {i_src_addr, i_dst_addr, i_src_port_in, i_dst_port_in,
                            i_proto_in, i_sort_value};
                predict_results(t_op'(i_op), seen_key);
            end
            if (i_out_valid && i_out_ready) begin
                check_result();
            end
        end
        o_errors  <= errors;
        o_pending <= expected_results.size();
        o_results <= checked;
        o_refused <= refused;
    end

endmodule

// ===== tb/testbench.sv =====
// top of the top-k sorted insertion list testbench: clock, reset, directed and random
// op stimulus under three idle patterns, watchdog and verdict
// depends on tksi_pkg, top_k_sorted_insert, tksi_list_checker
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import tksi_pkg::*;

    localparam int CAPACITY     = 16;
    localparam int PW           = $clog2(CAPACITY + 1);
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 50;
    localparam int RANDOM_OPS   = 25;

    logic          i_clk;
    logic          i_rst_n;
    logic          in_valid;
    logic          in_ready;
    logic [1:0]    op;
    logic [31:0]   src_addr;
    logic [31:0]   dst_addr;
    logic [15:0]   src_port;
    logic [15:0]   dst_port;
    logic [7:0]    proto;
    logic [63:0]   sort_value;
    logic          out_valid;
    logic          out_ready;
    logic [1:0]    kind;
    logic [PW-1:0] position;
    logic [31:0]   out_src_addr;
    logic [31:0]   out_dst_addr;
    logic [15:0]   out_src_port;
    logic [15:0]   out_dst_port;
    logic [7:0]    out_proto;
    logic [63:0]   out_value;
    logic          tied;
    logic          entry_valid;
    logic          last;

    int send_idle;
    int recv_idle;
    int stall_cycles;
    int ops_sent;
    int errors;
    int pending;
    int results;
    int refused;

    top_k_sorted_insert #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_op           (op),
        .i_src_addr     (src_addr),
        .i_dst_addr     (dst_addr),
        .i_src_port_in  (src_port),
        .i_dst_port_in  (dst_port),
        .i_proto_in     (proto),
        .i_sort_value   (sort_value),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_kind         (kind),
        .o_position     (position),
        .o_out_src_addr (out_src_addr),
        .o_out_dst_addr (out_dst_addr),
        .o_out_src_port (out_src_port),
        .o_out_dst_port (out_dst_port),
        .o_out_proto    (out_proto),
        .o_out_value    (out_value),
        .o_tied         (tied),
        .o_entry_valid  (entry_valid),
        .o_last         (last)
    );

    tksi_list_checker #(
        .CAPACITY(CAPACITY)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_op           (op),
        .i_src_addr     (src_addr),
        .i_dst_addr     (dst_addr),
        .i_src_port_in  (src_port),
        .i_dst_port_in  (dst_port),
        .i_proto_in     (proto),
        .i_sort_value   (sort_value),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_kind         (kind),
        .i_position     (position),
        .i_out_src_addr (out_src_addr),
        .i_out_dst_addr (out_dst_addr),
        .i_out_src_port (out_src_port),
        .i_out_dst_port (out_dst_port),
        .i_out_proto    (out_proto),
        .i_out_value    (out_value),
        .i_tied         (tied),
        .i_entry_valid  (entry_valid),
        .i_last         (last),
        .o_errors       (errors),
        .o_pending      (pending),
        .o_results      (results),
        .o_refused      (refused)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        out_ready <= (recv_idle == 0) || ($urandom_range(99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && ((in_valid && in_ready) || (out_valid && out_ready))) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("testbench: errors");
            $finish;
        end
    end

    function automatic t_entry rand_key();
        t_entry k;
        k.src = $urandom;
        if ($urandom_range(1) == 1) begin
            k.src[31:24] = 8'($urandom_range(3));
        end
        k.dst   = $urandom;
        k.sport = 16'($urandom);
        k.dport = 16'($urandom);
        k.proto = 8'($urandom);
        case ($urandom_range(9))
            0:          k.value = '0;
            1:          k.value = '1;
            2, 3, 4, 5: k.value = 64'($urandom_range(7));
            default:    k.value = {$urandom, $urandom};
        endcase
        return k;
    endfunction

    function automatic t_entry make_key(input logic [31:0] src, input logic [63:0] value);
        t_entry k;
        k       = rand_key();
        k.src   = src;
        k.value = value;
        return k;
    endfunction

    // one transfer on the op channel, with random idle cycles ahead of it
    task automatic send_op(input t_op code, input t_entry key);
        while (send_idle != 0 && $urandom_range(99) < send_idle) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
        end
        @(negedge i_clk);
        in_valid   <= 1'b1;
        op         <= code;
        src_addr   <= key.src;
        dst_addr   <= key.dst;
        src_port   <= key.sport;
        dst_port   <= key.dport;
        proto      <= key.proto;
        sort_value <= key.value;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        ops_sent++;
    endtask

    // insert bursts broken up by dumps, rare clears and unused op codes
    task automatic run_random(input int count);
        int done;
        int pick;
        done = 0;
        while (done < count) begin
            pick = $urandom_range(99);
            if (pick < 4) begin
                send_op(OP_NONE, rand_key());
            end else begin
                if (pick < 7) begin
                    send_op(OP_CLEAR, rand_key());
                end else if (pick < 22) begin
                    send_op(OP_DUMP, rand_key());
                end else begin
                    send_op(OP_INSERT, rand_key());
                end
                done++;
            end
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        in_valid     = 1'b0;
        out_ready    = 1'b0;
        op           = OP_INSERT;
        src_addr     = '0;
        dst_addr     = '0;
        src_port     = '0;
        dst_port     = '0;
        proto        = '0;
        sort_value   = '0;
        send_idle    = 33;
        recv_idle    = 64;
        stall_cycles = 0;
        ops_sent     = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_op(OP_DUMP, '0);
        send_op(OP_INSERT, '1);
        send_op(OP_INSERT, '0);
        send_op(OP_INSERT, make_key(32'h00ab_cdef, '1));
        send_op(OP_INSERT, make_key(32'hff12_3456, '1));
        send_op(OP_DUMP, '0);
        send_op(OP_NONE, '1);
        for (int i = 0; i < 12; i++) begin
            send_op(OP_INSERT, make_key($urandom, 64'd1000 + 64'($urandom_range(3))));
        end
        send_op(OP_INSERT, make_key(32'h0000_0001, '0));
        send_op(OP_INSERT, make_key($urandom, 64'd5000));
        send_op(OP_DUMP, '0);
        send_op(OP_CLEAR, '1);
        send_op(OP_DUMP, '0);

        run_random(RANDOM_OPS);
        send_idle = 64;
        recv_idle = 33;
        run_random(RANDOM_OPS);
        send_idle = 0;
        recv_idle = 0;
        run_random(RANDOM_OPS);

        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("summary: %0d ops transferred under three idle patterns, %0d results checked",
                 ops_sent, results);
        $display("summary: %0d inserts refused on a full list, %0d mismatches",
                 refused, errors);
        if (errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

// ===== top_k_sorted_insert.f =====
hw/rtl/tksi_pkg.sv
hw/rtl/tksi_dpath.sv
hw/rtl/tksi_ctrl.sv
hw/rtl/top_k_sorted_insert.sv
tb/tksi_list_checker.sv
tb/testbench.sv
